@@ sv/stc_pkg.sv @@
// shared types and constants of the temperature compensation block
`default_nettype none
package stc_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_T1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_T2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_T3 = 2'd2;

	// display range of the result in hundredths of a degree
	localparam logic signed [18:0] TEMP_MAX = 19'sd9999;
	localparam logic signed [18:0] TEMP_MIN = -19'sd9999;

	// reciprocals for the decimal split: x/100 = (x*5243)>>19 for x < 43699,
	// x/10 = (x*205)>>11 for x < 1029
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [7:0] RECIP_10 = 8'd205;
	localparam logic [6:0] HUNDRED = 7'd100;
	localparam logic [3:0] TEN = 4'd10;

	typedef struct packed {
		logic [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
	} stc_calib_t;

	// queued item: linear term (adc>>3) - 2*t1 and offset (adc>>4) - t1
	typedef struct packed {
		logic signed [17:0] lin;
		logic signed [16:0] dif;
	} stc_item_t;

	typedef struct packed {
		logic [14:0] temp;
		logic neg;
		logic [3:0] tens;
		logic [3:0] units;
		logic [3:0] tenths;
		logic [3:0] hundredths;
		logic sat;
	} stc_result_t;

endpackage
`default_nettype wire

@@ sv/stc_front.sv @@
// front end: calibration registers, input transfer and raw assembly
`default_nettype none
module stc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [stc_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] raw_msb,
	input wire logic [7:0] raw_lsb,
	input wire logic [7:0] raw_xlsb,
	input wire logic q_full,
	output logic push,
	output stc_pkg::stc_item_t push_item,
	output stc_pkg::stc_calib_t calib
);
	import stc_pkg::*;

	stc_calib_t calib_q;
	logic [19:0] adc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CALIB_T1: calib_q.t1 <= cfg_data;
				CFG_CALIB_T2: calib_q.t2 <= $signed(cfg_data);
				CFG_CALIB_T3: calib_q.t3 <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// low nibble of xlsb carries nothing
	assign adc = {raw_msb, raw_lsb, raw_xlsb[7:4]};

	assign in_stall = q_full;
	assign push = in_valid && !q_full;
	assign push_item.lin = $signed({1'b0, adc[19:3]}) - $signed({1'b0, calib_q.t1, 1'b0});
	assign push_item.dif = $signed({1'b0, adc[19:4]}) - $signed({1'b0, calib_q.t1});
	assign calib = calib_q;

endmodule
`default_nettype wire

@@ sv/stc_queue.sv @@
// short item queue between front end and compensation pipeline
`default_nettype none
module stc_queue #(
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire stc_pkg::stc_item_t push_item,
	output logic full,
	input wire logic pop,
	output logic avail,
	output stc_pkg::stc_item_t pop_item
);
	import stc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	stc_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full = (count_q == FULL_CNT);
	assign avail = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < FULL_CNT)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

@@ sv/stc_back.sv @@
// compensation pipeline: products, fine temperature, clamp and decimal digits
`default_nettype none
module stc_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire stc_pkg::stc_calib_t calib,
	input wire logic avail,
	input wire stc_pkg::stc_item_t item,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output stc_pkg::stc_result_t result
);
	import stc_pkg::*;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [33:0] p1_s1;
	logic signed [33:0] dd_s1;
	logic signed [22:0] v1_s2;
	logic signed [36:0] p3_s2;
	logic [14:0] temp_s3, temp_s4, temp_s5;
	logic sat_s3, sat_s4, sat_s5;
	logic [13:0] mag_s4;
	logic [6:0] q100_s4, q100_s5;
	logic [6:0] r100_s5;
	stc_result_t res_s6;

	logic signed [22:0] v2;
	logic signed [23:0] fine;
	logic signed [26:0] fine_x;
	logic signed [26:0] scaled;
	logic signed [18:0] temp_raw;
	logic signed [18:0] temp_clip;
	logic sat;
	logic [14:0] mag;
	logic [26:0] q100_prod;
	logic [13:0] r100_full;
	logic [14:0] qa_prod, qb_prod;
	logic [3:0] qa, qb;

	// whole pipeline holds only while a finished result waits
	assign en = !(vld_s6 && out_stall);
	assign pop = en && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= avail;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// fine temperature and rounding to hundredths
	assign v2 = p3_s2[36:14];
	assign fine = {v1_s2[22], v1_s2} + {v2[22], v2};
	assign fine_x = {{3{fine[23]}}, fine};
	assign scaled = (fine_x <<< 2) + fine_x + 27'sd128;
	assign temp_raw = scaled[26:8];

	always_comb begin
		temp_clip = temp_raw;
		sat = 1'b0;
		if (temp_raw > TEMP_MAX) begin
			temp_clip = TEMP_MAX;
			sat = 1'b1;
		end else if (temp_raw < TEMP_MIN) begin
			temp_clip = TEMP_MIN;
			sat = 1'b1;
		end
	end

	// decimal split of the magnitude
	assign mag = temp_s3[14] ? (15'd0 - temp_s3) : temp_s3;
	assign q100_prod = 27'(mag[13:0]) * 27'(RECIP_100);
	assign r100_full = mag_s4 - (14'(q100_s4) * 14'(HUNDRED));
	assign qa_prod = 15'(q100_s5) * 15'(RECIP_10);
	assign qb_prod = 15'(r100_s5) * 15'(RECIP_10);
	assign qa = qa_prod[14:11];
	assign qb = qb_prod[14:11];

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= item.lin * calib.t2;
			dd_s1 <= item.dif * item.dif;

			v1_s2 <= p1_s1[33:11];
			p3_s2 <= $signed({1'b0, dd_s1[31:12]}) * calib.t3;

			temp_s3 <= temp_clip[14:0];
			sat_s3 <= sat;

			temp_s4 <= temp_s3;
			sat_s4 <= sat_s3;
			mag_s4 <= mag[13:0];
			q100_s4 <= q100_prod[25:19];

			temp_s5 <= temp_s4;
			sat_s5 <= sat_s4;
			q100_s5 <= q100_s4;
			r100_s5 <= r100_full[6:0];

			res_s6.temp <= temp_s5;
			res_s6.neg <= temp_s5[14];
			res_s6.sat <= sat_s5;
			res_s6.tens <= qa;
			res_s6.units <= q100_s5[3:0] - 4'(qa * TEN);
			res_s6.tenths <= qb;
			res_s6.hundredths <= r100_s5[3:0] - 4'(qb * TEN);
		end
	end

	assign out_valid = vld_s6;
	assign result = res_s6;

`ifndef SYNTH
	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result.tens <= 4'd9) && (result.units <= 4'd9) &&
		(result.tenths <= 4'd9) && (result.hundredths <= 4'd9))
		else $error("decimal digit out of range");
	a_sign_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result.neg == result.temp[14])
		else $error("sign flag disagrees with temperature");
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result.sat |->
		($signed(result.temp) == 15'sd9999) || ($signed(result.temp) == -15'sd9999))
		else $error("clipped result not at a range limit");
`endif

endmodule
`default_nettype wire

@@ sv/sensor_temperature_compensation_top.sv @@
// top level of the sensor temperature compensation block
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    raw_msb, raw_lsb, raw_xlsb
// out      output     out_valid/out_stall  temp_hundredths, is_negative, digits, was_saturated
// cfg      input      cfg_we               cfg_index, cfg_data (calib t1, t2, t3)
//
// one sample per cycle sustained while no result waits on out_stall; a sample
// passes the queue and then six pipeline stages, set by the two chained products and the decimal split
// reset clears the calibration words, queue pointers and stage valid bits
// out_stall with a finished result waiting freezes the whole pipeline; the queue then absorbs up to DEPTH
// samples before in_stall rises
`default_nettype none
module sensor_temperature_compensation_top #(
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [stc_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] raw_msb,
	input wire logic [7:0] raw_lsb,
	input wire logic [7:0] raw_xlsb,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [14:0] temp_hundredths,
	output logic is_negative,
	output logic [3:0] digit_tens,
	output logic [3:0] digit_units,
	output logic [3:0] digit_tenths,
	output logic [3:0] digit_hundredths,
	output logic was_saturated
);
	import stc_pkg::*;

	stc_calib_t calib;
	stc_item_t push_item;
	stc_item_t pop_item;
	stc_result_t result;
	logic q_full;
	logic push;
	logic pop;
	logic avail;

	stc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_msb(raw_msb),
		.raw_lsb(raw_lsb),
		.raw_xlsb(raw_xlsb),
		.q_full(q_full),
		.push(push),
		.push_item(push_item),
		.calib(calib)
	);

	stc_queue #(
		.DEPTH(DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.avail(avail),
		.pop_item(pop_item)
	);

	stc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.calib(calib),
		.avail(avail),
		.item(pop_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result)
	);

	assign temp_hundredths = $signed(result.temp);
	assign is_negative = result.neg;
	assign digit_tens = result.tens;
	assign digit_units = result.units;
	assign digit_tenths = result.tenths;
	assign digit_hundredths = result.hundredths;
	assign was_saturated = result.sat;

endmodule
`default_nettype wire
